// ----- rtl/box_filter_mip_chain_top_assert.svh -----
// assertion macros for the mip chain top level
`ifndef BOX_FILTER_MIP_CHAIN_TOP_ASSERT_SVH
`define BOX_FILTER_MIP_CHAIN_TOP_ASSERT_SVH
// implication checked on every clock outside reset
`define BFM_ASSERT_IMP(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);
// next-cycle implication outside reset
`define BFM_ASSERT_NXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);
`endif

// ----- rtl/bfm_pkg.sv -----
// ----------------------------------------------------------------------------
// bfm_pkg
// types and constants shared by the box filter mip chain modules
// ----------------------------------------------------------------------------
`default_nettype none
package bfm_pkg;
   localparam int MaxDimDefault    = 2048;
   localparam int MaxLevelsDefault = 12;
   localparam int CfgIdxWidth      = 2;
   localparam logic [CfgIdxWidth-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CfgIdxWidth-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CfgIdxWidth-1:0] CSR_MIPEN  = 2'd2;

   typedef struct packed {
      logic [7:0] alpha_in;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [3:0]  mip_level;
      logic [10:0] pixel_x;
      logic [10:0] pixel_y;
      logic [7:0]  blue_out;
      logic [7:0]  green_out;
      logic [7:0]  red_out;
      logic [7:0]  alpha_out;
      logic        last_of_run;
      logic        image_done;
   } rsp_type;

   // controller -> datapath commands
   typedef struct packed {
      logic load;     // capture a new input pixel, start at level 0
      logic lookup;   // read row store for current level
      logic compute;  // update state and form the result
      logic emit;     // result handed to output register
      logic clear;    // restart all positions
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic cont;     // another level follows this one
   } sts_type;

   function automatic logic [7:0] avg4(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c, input logic [7:0] d);
      logic [9:0] s;
      s = 10'(a) + 10'(b) + 10'(c) + 10'(d) + 10'd2;
      return s[9:2];
   endfunction

   function automatic logic [31:0] box4(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c, input logic [31:0] d);
      logic [31:0] r;
      for (int i = 0; i < 4; i++)
         r[i*8 +: 8] = avg4(a[i*8 +: 8], b[i*8 +: 8], c[i*8 +: 8], d[i*8 +: 8]);
      return r;
   endfunction
endpackage
`default_nettype wire

// ----- rtl/bfm_ctrl.sv -----
// ----------------------------------------------------------------------------
// bfm_ctrl
// sequencer: accept a pixel, then walk the levels one at a time
// ----------------------------------------------------------------------------
`default_nettype none
module bfm_ctrl import bfm_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire logic    out_busy,
   input  wire logic    cfg_write,
   input  sts_type      sts,
   output cmd_type      cmd
);
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_CALC = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.clear   = cfg_write;
      req_stall   = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.lookup = 1'b1;
            state_in   = ST_CALC;
         end
         ST_CALC: begin
            // wait for the output register to free up
            if (!out_busy) begin
               cmd.compute = 1'b1;
               cmd.emit    = 1'b1;
               state_in    = sts.cont ? ST_READ : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end
endmodule
`default_nettype wire

// ----- rtl/bfm_datapath.sv -----
// ----------------------------------------------------------------------------
// bfm_datapath
// level positions, row store, held pixels and the 2x2 average
// ----------------------------------------------------------------------------
`default_nettype none
module bfm_datapath import bfm_pkg::*; #(
   parameter int MAX_DIM    = MaxDimDefault,
   parameter int MAX_LEVELS = MaxLevelsDefault
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  cmd_type      cmd,
   input  req_type      req_data,
   input  wire logic [11:0] cfg_w,
   input  wire logic [11:0] cfg_h,
   input  wire logic    cfg_mip,
   output sts_type      sts,
   output rsp_type      res
);
   localparam int DW    = $clog2(MAX_DIM + 1);
   localparam int PW    = $clog2(MAX_DIM);
   localparam int LW    = $clog2(MAX_LEVELS);
   localparam int DEPTH = 2 * MAX_DIM;
   localparam int AW    = $clog2(DEPTH);

   logic [PW-1:0]  col_ff [MAX_LEVELS];
   logic [PW-1:0]  row_ff [MAX_LEVELS];
   logic [31:0]    held_ff [MAX_LEVELS];
   logic [31:0]    mem [DEPTH];

   logic [LW-1:0]  lvl_ff;
   logic [DW-1:0]  lw_ff, lh_ff;
   logic [AW:0]    off_ff;
   logic [31:0]    px_ff;
   logic           last_pix_ff;
   logic [31:0]    rda_ff, rdb_ff;

   // clamp configured dimensions
   function automatic logic [DW-1:0] clampd(input logic [11:0] v);
      if (v == 12'd0) return DW'(1);
      if (32'(v) > MAX_DIM) return DW'(MAX_DIM);
      return DW'(v);
   endfunction

   logic [DW-1:0] cw, ch;
   assign cw = clampd(cfg_w);
   assign ch = clampd(cfg_h);

   // current level position, clamped
   logic [DW-1:0] x, y, nw, nh;
   logic [AW:0]   ia, ib;
   always_comb begin
      x  = {1'b0, col_ff[lvl_ff]};
      y  = {1'b0, row_ff[lvl_ff]};
      if (x >= lw_ff) x = lw_ff - 1'b1;
      if (y >= lh_ff) y = lh_ff - 1'b1;
      nw = (lw_ff > 1) ? (lw_ff >> 1) : DW'(1);
      nh = (lh_ff > 1) ? (lh_ff >> 1) : DW'(1);
      ia = off_ff + (AW+1)'({x[DW-1:1], 1'b0});
      ib = off_ff + (AW+1)'(x);
   end

   // cascade decision for this level
   logic go, inside_w, top, bottom, left, right, produced;
   logic [31:0] avg;
   always_comb begin
      go       = cfg_mip && !(lw_ff == 1 && lh_ff == 1)
                 && (32'(lvl_ff) + 1 < MAX_LEVELS);
      inside_w = ({1'b0, x} < {nw, 1'b0}) && ({1'b0, y} < {nh, 1'b0});
      top      = (lh_ff == 1) || !y[0];
      bottom   = (lh_ff == 1) ||  y[0];
      left     = (lw_ff == 1) || !x[0];
      right    = (lw_ff == 1) ||  x[0];
      produced = go && inside_w && bottom && right;
      // a single column pairs the pixel with itself on the left
      avg      = box4(rda_ff, rdb_ff, left ? px_ff : held_ff[lvl_ff], px_ff);
   end
   assign sts.cont = produced;

   // row store read in the lookup cycle, a top-row pixel sees itself
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         rda_ff <= mem[ia[AW-1:0]];
         rdb_ff <= top ? px_ff : mem[ib[AW-1:0]];
      end
      if (cmd.compute && go && inside_w && top && ib < (AW+1)'(DEPTH))
         mem[ib[AW-1:0]] <= px_ff;
   end

   // level walker
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff       <= req_data;
         lvl_ff      <= '0;
         lw_ff       <= cw;
         lh_ff       <= ch;
         off_ff      <= '0;
         last_pix_ff <= ((col_ff[0] >= PW'(cw - 1'b1)) || (DW'(col_ff[0]) >= cw))
                        && ((DW'(row_ff[0]) >= ch - 1'b1));
      end else if (cmd.compute && produced) begin
         px_ff  <= avg;
         lvl_ff <= lvl_ff + 1'b1;
         lw_ff  <= nw;
         lh_ff  <= nh;
         off_ff <= off_ff + (AW+1)'(lw_ff);
      end
      if (cmd.compute && go && inside_w && bottom && left)
         held_ff[lvl_ff] <= px_ff;
   end

   // level positions
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < MAX_LEVELS; i++) begin
            col_ff[i] <= '0;
            row_ff[i] <= '0;
         end
      end else if (cmd.compute) begin
         if (x + 1'b1 >= lw_ff) begin
            col_ff[lvl_ff] <= '0;
            row_ff[lvl_ff] <= (y + 1'b1 >= lh_ff) ? '0 : PW'(y + 1'b1);
         end else begin
            col_ff[lvl_ff] <= PW'(x + 1'b1);
            row_ff[lvl_ff] <= PW'(y);
         end
      end
   end

   // result formation
   always_comb begin
      res.mip_level   = 4'(lvl_ff);
      res.pixel_x     = 11'(x);
      res.pixel_y     = 11'(y);
      res.blue_out    = px_ff[7:0];
      res.green_out   = px_ff[15:8];
      res.red_out     = px_ff[23:16];
      res.alpha_out   = px_ff[31:24];
      res.last_of_run = !produced;
      res.image_done  = !produced && last_pix_ff;
   end
endmodule
`default_nettype wire

// ----- rtl/box_filter_mip_chain_top.sv -----
// ----------------------------------------------------------------------------
// box_filter_mip_chain_top
// streaming 2x2 box filter mip chain generator
// ----------------------------------------------------------------------------
// Each accepted pixel produces one result per level it completes, 1 to
// MAX_LEVELS results; per result the sequencer reads the row store, then
// averages and updates state once the output register is free; new pixels
// stall until the last result. Results sit in one output register.
`default_nettype none
module box_filter_mip_chain_top import bfm_pkg::*; #(
   parameter int MAX_DIM    = MaxDimDefault,
   parameter int MAX_LEVELS = MaxLevelsDefault
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   input  req_type   req_data,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output rsp_type   rsp_data,
   input  wire logic csr_valid,
   output logic      csr_ready,
   input  wire logic [CfgIdxWidth-1:0] csr_index,
   input  wire logic [11:0] csr_data
);
   `include "box_filter_mip_chain_top_assert.svh"

   logic [11:0] w_ff, h_ff;
   logic        mip_ff;
   logic        cfg_write;
   cmd_type     cmd;
   sts_type     sts;
   rsp_type     res;
   logic        out_busy;

   assign csr_ready = 1'b1;
   assign cfg_write = csr_valid && (csr_index == CSR_WIDTH || csr_index == CSR_HEIGHT
                                    || csr_index == CSR_MIPEN);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= 12'd1; h_ff <= 12'd1; mip_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WIDTH:  w_ff   <= csr_data;
            CSR_HEIGHT: h_ff   <= csr_data;
            CSR_MIPEN:  mip_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign out_busy = rsp_valid && rsp_stall;

   bfm_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .out_busy, .cfg_write, .sts, .cmd
   );

   bfm_datapath #(.MAX_DIM(MAX_DIM), .MAX_LEVELS(MAX_LEVELS)) u_dp (
      .clock, .reset, .cmd, .req_data, .cfg_w(w_ff), .cfg_h(h_ff), .cfg_mip(mip_ff),
      .sts, .res
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (cmd.emit) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
      if (cmd.emit) rsp_data <= res;
   end

   `BFM_ASSERT_IMP(a_emit_free, clock, reset, cmd.emit, !out_busy, "emit over held result")
   `BFM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                   rsp_valid && $stable(rsp_data), "stalled result changed")
   `BFM_ASSERT_IMP(a_done_run, clock, reset, rsp_valid && rsp_data.image_done,
                   rsp_data.last_of_run, "image_done without last_of_run")
endmodule
`default_nettype wire
